/* rtl/cscan_pkg.sv */
// ----------------------------------------------------------------------------
// cscan_pkg
// shared types, codes and helpers for the c-scan request scheduler
// ----------------------------------------------------------------------------
package cscan_pkg;

  localparam logic       OP_LOAD = 1'b0;
  localparam logic       OP_RUN  = 1'b1;

  localparam logic [1:0] KIND_REQ    = 2'd0;
  localparam logic [1:0] KIND_TRAVEL = 2'd1;
  localparam logic [1:0] KIND_EMPTY  = 2'd2;

  localparam logic [16:0] DISK_CYL_RESET = 17'd65536;
  localparam int          CYL_W   = 16;
  localparam int          TOTAL_W = 17;

  // commands from controller to datapath
  typedef struct packed {
    logic ld_ins;      // latch new request, read top entry
    logic ins_shift;   // move entry up one slot
    logic ins_put;     // write new request into its slot
    logic ld_run;      // latch head, take batch, read entry 0
    logic nxt_idx;     // advance scan index, read next entry
    logic srch_hit;    // first entry above head found, reread it
    logic srch_miss;   // no entry above head
    logic step_emit;   // emit a served request
    logic lo_phase;    // step_emit belongs to the low group
    logic trav_emit;   // emit travel to last cylinder
    logic wrap;        // jump to cylinder 0, read entry 0
    logic empty_emit;  // emit empty-run item
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic ins_room;    // store not full
    logic cnt_zero;    // store empty
    logic ins_gt;      // read entry above new request
    logic pos_one;     // insertion slot is 1
    logic hit;         // read entry above head
    logic idx_end;     // index at last entry
    logic lo_end;      // index at last low-group entry
    logic pos_zero;    // no low group
    logic cur_at_top;  // head at last cylinder
    logic out_free;    // output register can take an item
  } sts_t;

  function automatic logic [CYL_W-1:0] last_cyl(input logic [16:0] d);
    logic [CYL_W-1:0] r;
    if (d == '0) begin
      r = '0;
    end else if (d[16]) begin
      r = '1;
    end else begin
      r = d[CYL_W-1:0] - 16'd1;
    end
    return r;
  endfunction

  function automatic logic [CYL_W-1:0] clamp_cyl(input logic [CYL_W-1:0] c,
                                                 input logic [CYL_W-1:0] top);
    return (c > top) ? top : c;
  endfunction

endpackage

/* rtl/cscan_disk_request_scheduler_top.sv */
// ----------------------------------------------------------------------------
// cscan_disk_request_scheduler_top
// c-scan disk request scheduler: sorted request batch, circular service
// ----------------------------------------------------------------------------
// load item: accepted while idle, then k entries moved up one slot each (k at most
//   MAX_REQUESTS-1) and the new request written before the next item is taken
// run item: a search over the batch, then one result per cycle while the output
//   register can take it; paced by the single read port of the request store
// results leave through an output register, so an item can be taken while
//   the last result of a run still waits
// reset (rst_n low, synchronous): batch empty, disk_cylinders = 65536,
//   output empty; the request store itself is not cleared
module cscan_disk_request_scheduler_top #(
  parameter int MAX_REQUESTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration: disk_cylinders
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,
  // input items
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] cylinder
  input  logic        in_tuser,   // [0] op
  // result items
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // [15:0] target_cylinder, [31:16] from_cylinder,
                                  // [47:32] seek_distance, [64:48] total_seek
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast   // last result of a run
);
  import cscan_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // the user is to write the register only while idle; the block does not enforce it, and the port never stalls
  assign cfg_ready = 1'b1;

  // sequencer
  cscan_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // store, scan state, arithmetic and output register
  cscan_dp #(
    .MAX_REQUESTS (MAX_REQUESTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_cyl     (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/cscan_dp.sv */
// ----------------------------------------------------------------------------
// cscan_dp
// request store, scan registers, seek arithmetic and output register
// ----------------------------------------------------------------------------
module cscan_dp #(
  parameter int MAX_REQUESTS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [16:0]            cfg_data,
  input  logic [15:0]            in_cyl,
  input  cscan_pkg::cmd_t        cmd,
  output cscan_pkg::sts_t        sts,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [71:0]            out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast
);
  import cscan_pkg::*;

  localparam int AW = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int CW = $clog2(MAX_REQUESTS + 1);

  logic [CYL_W-1:0] mem [MAX_REQUESTS];
  logic [CYL_W-1:0] rd_q;

  logic [16:0]      cfg_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0]    n_r, n_nxt;
  logic [CW-1:0]    pos_r, pos_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [CYL_W-1:0] v_r, v_nxt;
  logic [CYL_W-1:0] head0_r, head0_nxt;
  logic [CYL_W-1:0] cur_r, cur_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_kind_r, out_kind_nxt;
  logic [CYL_W-1:0]   out_target_r, out_target_nxt;
  logic [CYL_W-1:0]   out_from_r, out_from_nxt;
  logic [CYL_W-1:0]   out_dist_r, out_dist_nxt;
  logic [TOTAL_W-1:0] out_total_r, out_total_nxt;
  logic               out_last_r, out_last_nxt;

  logic [CYL_W-1:0]   top, cyl_c, rd_c, emit_dist;
  logic [TOTAL_W-1:0] total_sum;
  logic [CW-1:0]      idx_ext, idx_inc, cnt_dec, pos_dec2;
  logic               rd_en, wr_en, out_load, step_last;
  logic [AW-1:0]      rd_addr;
  logic [CYL_W-1:0]   wr_data;

  assign top      = last_cyl(cfg_r);
  assign cyl_c    = clamp_cyl(in_cyl, top);
  assign rd_c     = clamp_cyl(rd_q, top);
  assign idx_ext  = CW'(idx_r);
  assign idx_inc  = idx_ext + CW'(1);
  assign cnt_dec  = cnt_r - CW'(1);
  assign pos_dec2 = pos_r - CW'(2);

  // status
  always_comb begin
    sts            = '0;
    sts.ins_room   = (cnt_r < CW'(MAX_REQUESTS));
    sts.cnt_zero   = (cnt_r == '0);
    sts.ins_gt     = (rd_q > v_r);
    sts.pos_one    = (pos_r == CW'(1));
    sts.hit        = (rd_c > head0_r);
    sts.idx_end    = (idx_inc == n_r);
    sts.lo_end     = (idx_inc == pos_r);
    sts.pos_zero   = (pos_r == '0);
    sts.cur_at_top = (cur_r == top);
    sts.out_free   = !out_valid_r || out_tready;
  end

  // store read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    priority if (cmd.ld_ins && !sts.cnt_zero) begin
      rd_en   = 1'b1;
      rd_addr = cnt_dec[AW-1:0];
    end else if (cmd.ins_shift && !sts.pos_one) begin
      rd_en   = 1'b1;
      rd_addr = pos_dec2[AW-1:0];
    end else if (cmd.ld_run || cmd.wrap) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (cmd.nxt_idx) begin
      rd_en   = 1'b1;
      rd_addr = idx_inc[AW-1:0];
    end else if (cmd.srch_hit) begin
      rd_en   = 1'b1;
      rd_addr = idx_r;
    end else begin
      rd_en   = 1'b0;
      rd_addr = '0;
    end
  end

  assign wr_en   = cmd.ins_shift || cmd.ins_put;
  assign wr_data = cmd.ins_shift ? rd_q : v_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[pos_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // seek arithmetic
  assign emit_dist = cmd.trav_emit ? (top - cur_r) : (rd_c - cur_r);
  assign total_sum = total_r + {1'b0, emit_dist};
  assign step_last = cmd.lo_phase ? sts.lo_end
                                  : (sts.idx_end && sts.pos_zero && (rd_c == top));
  assign out_load  = cmd.step_emit || cmd.trav_emit || cmd.empty_emit;

  always_comb begin
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    pos_nxt   = pos_r;
    idx_nxt   = idx_r;
    v_nxt     = v_r;
    head0_nxt = head0_r;
    cur_nxt   = cur_r;
    total_nxt = total_r;

    if (cmd.ld_ins) begin
      v_nxt   = cyl_c;
      pos_nxt = cnt_r;
    end
    if (cmd.ins_shift) begin
      pos_nxt = pos_r - CW'(1);
    end
    if (cmd.ins_put) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (cmd.ld_run) begin
      head0_nxt = cyl_c;
      cur_nxt   = cyl_c;
      total_nxt = '0;
      n_nxt     = cnt_r;
      cnt_nxt   = '0;
      idx_nxt   = '0;
    end
    if (cmd.nxt_idx) begin
      idx_nxt = idx_inc[AW-1:0];
    end
    if (cmd.srch_hit) begin
      pos_nxt = idx_ext;
    end
    if (cmd.srch_miss) begin
      pos_nxt = n_r;
    end
    if (cmd.step_emit) begin
      cur_nxt   = rd_c;
      total_nxt = total_sum;
    end
    if (cmd.trav_emit) begin
      total_nxt = total_sum;
    end
    if (cmd.wrap) begin
      cur_nxt = '0;
      idx_nxt = '0;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_target_nxt = out_target_r;
    out_from_nxt   = out_from_r;
    out_dist_nxt   = out_dist_r;
    out_total_nxt  = out_total_r;
    out_last_nxt   = out_last_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_from_nxt  = cur_r;
      if (cmd.empty_emit) begin
        out_kind_nxt   = KIND_EMPTY;
        out_target_nxt = head0_r;
        out_dist_nxt   = '0;
        out_total_nxt  = '0;
        out_last_nxt   = 1'b1;
      end else if (cmd.trav_emit) begin
        out_kind_nxt   = KIND_TRAVEL;
        out_target_nxt = top;
        out_dist_nxt   = emit_dist;
        out_total_nxt  = total_sum;
        out_last_nxt   = sts.pos_zero;
      end else begin
        out_kind_nxt   = KIND_REQ;
        out_target_nxt = rd_c;
        out_dist_nxt   = emit_dist;
        out_total_nxt  = total_sum;
        out_last_nxt   = step_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= DISK_CYL_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        cfg_r <= cfg_data;
      end
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r          <= n_nxt;
    pos_r        <= pos_nxt;
    idx_r        <= idx_nxt;
    v_r          <= v_nxt;
    head0_r      <= head0_nxt;
    cur_r        <= cur_nxt;
    total_r      <= total_nxt;
    out_kind_r   <= out_kind_nxt;
    out_target_r <= out_target_nxt;
    out_from_r   <= out_from_nxt;
    out_dist_r   <= out_dist_nxt;
    out_total_r  <= out_total_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_total_r, out_dist_r, out_from_r, out_target_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_REQUESTS))
    else $error("request count above store depth");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_run |=> cnt_r == '0)
    else $error("batch not emptied by run");

  a_dist_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_dist_r == (out_target_r - out_from_r))
    else $error("seek distance does not match move");

endmodule

/* rtl/cscan_ctrl.sv */
// ----------------------------------------------------------------------------
// cscan_ctrl
// sequencer for insertion, search, service passes and output handoff
// ----------------------------------------------------------------------------
module cscan_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_op,
  output logic                   in_tready,
  input  cscan_pkg::sts_t        sts,
  output cscan_pkg::cmd_t        cmd
);
  import cscan_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_INS_CMP = 8'b0000_0010,
    S_INS_PUT = 8'b0000_0100,
    S_SRCH    = 8'b0000_1000,
    S_HI      = 8'b0001_0000,
    S_TRAV    = 8'b0010_0000,
    S_LO      = 8'b0100_0000,
    S_EMPTY   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_op == OP_RUN) begin
            cmd.ld_run = 1'b1;
            state_nxt  = sts.cnt_zero ? S_EMPTY : S_SRCH;
          end else if (sts.ins_room) begin
            cmd.ld_ins = 1'b1;
            state_nxt  = sts.cnt_zero ? S_INS_PUT : S_INS_CMP;
          end
        end
      end
      S_INS_CMP: begin
        if (sts.ins_gt) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = sts.pos_one ? S_INS_PUT : S_INS_CMP;
        end else begin
          cmd.ins_put = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_INS_PUT: begin
        cmd.ins_put = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_SRCH: begin
        if (sts.hit) begin
          cmd.srch_hit = 1'b1;
          state_nxt    = S_HI;
        end else if (sts.idx_end) begin
          cmd.srch_miss = 1'b1;
          state_nxt     = S_TRAV;
        end else begin
          cmd.nxt_idx = 1'b1;
        end
      end
      S_HI: begin
        if (sts.out_free) begin
          cmd.step_emit = 1'b1;
          if (sts.idx_end) begin
            state_nxt = S_TRAV;
          end else begin
            cmd.nxt_idx = 1'b1;
          end
        end
      end
      S_TRAV: begin
        if (sts.cur_at_top || sts.out_free) begin
          cmd.trav_emit = !sts.cur_at_top;
          cmd.wrap      = 1'b1;
          state_nxt     = sts.pos_zero ? S_IDLE : S_LO;
        end
      end
      S_LO: begin
        if (sts.out_free) begin
          cmd.step_emit = 1'b1;
          cmd.lo_phase  = 1'b1;
          if (sts.lo_end) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.nxt_idx = 1'b1;
          end
        end
      end
      S_EMPTY: begin
        if (sts.out_free) begin
          cmd.empty_emit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step_emit || cmd.trav_emit || cmd.empty_emit) |-> sts.out_free)
    else $error("item emitted into a full output register");

  a_ins_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_ins |-> sts.ins_room)
    else $error("insertion started on a full store");

  a_put_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_put |=> state_r == S_IDLE)
    else $error("insertion did not return to idle");

endmodule

/* sim/cscan_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cscan_checker
// watches the config, request and move channels of the c-scan scheduler,
// keeps its own sorted batch, predicts every move of a run and compares
// each move item against the oldest prediction
// ----------------------------------------------------------------------------
module cscan_checker #(
  parameter int MAX_REQUESTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [16:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [71:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          checked
);
  import cscan_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] target;
    logic [15:0] from;
    logic [15:0] seek;
    logic [16:0] total;
    logic        last;
  } move_t;

  move_t       moves_due[$];
  logic [15:0] batch[MAX_REQUESTS];
  int          batch_len;
  logic [16:0] disk_cyl;
  int          mismatches;
  int          compared;

  // highest reachable cylinder for a register value, out-of-range folded in
  function automatic logic [15:0] final_cyl(input logic [16:0] d);
    if (d == 17'd0) return 16'd0;
    if (d >= 17'd65536) return 16'hFFFF;
    return 16'(d - 17'd1);
  endfunction

  function automatic void push_move(input logic [1:0] kind, input logic [15:0] to,
                                    input logic [15:0] from, input logic [16:0] total);
    move_t m;
    m.kind   = kind;
    m.target = to;
    m.from   = from;
    m.seek   = to - from;
    m.total  = total;
    m.last   = 1'b0;
    moves_due.push_back(m);
  endfunction

  function automatic void insert_request(input logic [15:0] cyl);
    logic [15:0] top;
    logic [15:0] v;
    int          pos;
    top = final_cyl(disk_cyl);
    v   = (cyl > top) ? top : cyl;
    if (batch_len >= MAX_REQUESTS) return;
    pos = batch_len;
    // equal requests stay ahead of the new one
    while (pos > 0 && batch[pos-1] > v) begin
      batch[pos] = batch[pos-1];
      pos--;
    end
    batch[pos] = v;
    batch_len++;
  endfunction

  function automatic void schedule_batch(input logic [15:0] cyl);
    logic [15:0] top;
    logic [15:0] head;
    logic [15:0] r;
    logic [16:0] total;
    int          n;
    int          split;
    int          i;
    top  = final_cyl(disk_cyl);
    head = (cyl > top) ? top : cyl;
    n    = batch_len;
    batch_len = 0;
    if (n == 0) begin
      push_move(KIND_EMPTY, head, head, 17'd0);
    end else begin
      // stored entries are clamped again, the register may have shrunk
      split = n;
      for (i = n - 1; i >= 0; i--) begin
        if (((batch[i] > top) ? top : batch[i]) > head) split = i;
      end
      total = '0;
      for (i = split; i < n; i++) begin
        r     = (batch[i] > top) ? top : batch[i];
        total = total + 17'(r - head);
        push_move(KIND_REQ, r, head, total);
        head  = r;
      end
      if (head != top) begin
        total = total + 17'(top - head);
        push_move(KIND_TRAVEL, top, head, total);
      end
      head = '0;
      for (i = 0; i < split; i++) begin
        r     = (batch[i] > top) ? top : batch[i];
        total = total + 17'(r - head);
        push_move(KIND_REQ, r, head, total);
        head  = r;
      end
    end
    moves_due[moves_due.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    move_t got;
    move_t want;
    if (!rst_n) begin
      moves_due.delete();
      batch_len = 0;
      disk_cyl  = DISK_CYL_RESET;
    end else begin
      if (cfg_valid && cfg_ready) disk_cyl = cfg_data;
      // compare before predicting, a move never answers an item of this edge
      if (out_tvalid && out_tready) begin
        got.kind   = out_tuser;
        got.target = out_tdata[15:0];
        got.from   = out_tdata[31:16];
        got.seek   = out_tdata[47:32];
        got.total  = out_tdata[64:48];
        got.last   = out_tlast;
        compared++;
        if (moves_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected move kind %0d to %0d from %0d dist %0d total %0d last %0d",
                     $realtime, got.kind, got.target, got.from, got.seek, got.total, got.last);
        end else begin
          want = moves_due.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: move mismatch", $realtime);
              $display("  expected kind %0d to %0d from %0d dist %0d total %0d last %0d",
                       want.kind, want.target, want.from, want.seek, want.total, want.last);
              $display("  actual   kind %0d to %0d from %0d dist %0d total %0d last %0d",
                       got.kind, got.target, got.from, got.seek, got.total, got.last);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == OP_LOAD) insert_request(in_tdata);
        else schedule_batch(in_tdata);
      end
    end
    fail_count <= mismatches;
    pending    <= moves_due.size();
    checked    <= compared;
  end

endmodule

/* sim/tb_cscan_disk_request_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cscan_disk_request_scheduler_top
// drives request batches and schedule runs into the c-scan scheduler under
// several disk sizes and idle patterns; a checker beside the block predicts
// and compares every move
// ----------------------------------------------------------------------------
module tb_cscan_disk_request_scheduler_top;
  import cscan_pkg::*;

  localparam int MAX_REQUESTS  = 16;
  // covers the longest insertion walk plus the output register
  localparam int SETTLE_CYCLES = 40;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [16:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic [15:0] in_tdata   = '0;
  logic        in_tuser   = OP_LOAD;
  logic        out_tready = 1'b0;
  logic        cfg_ready;
  logic        in_tready;
  logic        out_tvalid;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int          fail_count;
  int          pending;
  int          checked;

  // idle percentages: sender gaps and receiver stalls
  int          in_gap_pct    = 0;
  int          out_stall_pct = 0;
  int          loads_sent    = 0;
  int          runs_sent     = 0;
  int          disk_settings = 0;
  int          live_items    = 0;
  logic [16:0] disk_now      = DISK_CYL_RESET;
  logic [15:0] prev_cyl      = '0;

  always #5 clk = ~clk;

  // receiver stalls at random, percentage changes per phase
  always @(posedge clk) out_tready <= ($urandom_range(99) >= out_stall_pct);

  cscan_disk_request_scheduler_top #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  cscan_checker #(
    .MAX_REQUESTS(MAX_REQUESTS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .fail_count(fail_count),
    .pending   (pending),
    .checked   (checked)
  );

  // one item with random gaps ahead of it; valid stays high into the next
  // item when no gap is drawn
  task automatic send_item(input logic op, input logic [15:0] cyl);
    while ($urandom_range(99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= cyl;
    do @(posedge clk); while (!in_tready);
    prev_cyl = cyl;
    if (op == OP_LOAD) loads_sent++;
    else runs_sent++;
  endtask

  // stop sending and wait until every predicted move came back, then let
  // a pending insertion finish
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_disk(input logic [16:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    disk_now = value;
    disk_settings++;
  endtask

  task automatic set_idling(input int in_pct, input int out_pct);
    in_gap_pct = in_pct;
    out_stall_pct <= out_pct;
  endtask

  // cylinder mix: full range, around the disk end, exact end, repeats
  function automatic logic [15:0] pick_cyl();
    logic [15:0] lim;
    int          sel;
    lim = (disk_now == 17'd0) ? 16'd0 :
          (disk_now >= 17'd65536) ? 16'hFFFF : 16'(disk_now - 17'd1);
    sel = $urandom_range(9);
    if (sel < 4) return 16'($urandom);
    if (sel < 7) return 16'($urandom_range((lim > 16'hFFFC) ? 32'hFFFF : lim + 3, 0));
    if (sel < 8) return lim;
    return prev_cyl;
  endfunction

  // one batch then a run; sometimes a bare run or an overfilled batch
  task automatic run_batch();
    int sel;
    int n;
    int i;
    sel = $urandom_range(99);
    if (sel < 8) n = $urandom_range(MAX_REQUESTS + 3, MAX_REQUESTS + 1);
    else if (sel < 14) n = 0;
    else n = $urandom_range(MAX_REQUESTS, 1);
    for (i = 0; i < n; i++) send_item(OP_LOAD, pick_cyl());
    send_item(OP_RUN, pick_cyl());
    // loads dropped by a full store do not count
    live_items += ((n > MAX_REQUESTS) ? MAX_REQUESTS : n) + 1;
  endtask

  task automatic random_phase(input int quota, input logic [16:0] disk);
    int goal;
    set_disk(disk);
    goal = live_items + quota;
    while (live_items < goal) run_batch();
  endtask

  initial begin
    int i;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(9, 49);

    // full-size disk: empty run, then a batch with both ends and duplicates;
    // head sits below the top pair so the last cylinder is reached by a
    // request and no travel move follows
    set_disk(17'd65536);
    send_item(OP_RUN, 16'hFFFF);
    send_item(OP_LOAD, 16'hFFFF);
    send_item(OP_LOAD, 16'h0000);
    send_item(OP_LOAD, 16'd100);
    send_item(OP_LOAD, 16'd100);
    send_item(OP_LOAD, 16'hFFFF);
    send_item(OP_RUN, 16'd100);

    // register zero acts as one cylinder: head beyond disk, nothing above it
    set_disk(17'd0);
    send_item(OP_LOAD, 16'd7);
    send_item(OP_RUN, 16'd40000);

    // oversized register value, fill past capacity, then shrink the disk
    // before the run so stored requests get clamped again
    set_disk(17'h1FFFF);
    for (i = 0; i <= MAX_REQUESTS; i++) send_item(OP_LOAD, 16'hFFFF - 16'(i * 4369));
    set_disk(17'd1000);
    send_item(OP_RUN, 16'd500);

    // random batches, receiver stalling about half the time
    random_phase(30, 17'd65536);
    random_phase(30, 17'($urandom_range(65535, 2)));

    // sender idle about half the time, tiny disks force clamping and duplicates
    set_idling(49, 9);
    random_phase(30, 17'd1);
    random_phase(30, 17'($urandom_range(300, 2)));

    // back to back, no idling on either side
    set_idling(0, 0);
    random_phase(30, 17'($urandom_range(65536, 1)));
    random_phase(30, 17'h1FFFF);

    drain();
    $display("run covered %0d loads and %0d schedule runs under %0d disk sizes",
             loads_sent, runs_sent, disk_settings);
    $display("%0d moves compared, %0d still outstanding", checked, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #3_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
